// ===== design/tspq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tspq_pkg
// Shared types and defaults of the tagged stable priority queue.
// ----------------------------------------------------------------------------
package tspq_pkg;

  localparam int TspqCapacity     = 64;
  localparam int TspqIdBits       = 16;
  localparam int TspqPriorityBits = 8;
  localparam int TspqHandleBits   = 32;

  typedef enum logic [1:0] {
    ACT_POST   = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_CMP,
    S_POS_RD,
    S_POS_CMP,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_FIND_RD,
    S_FIND_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_PEEK_RD,
    S_PEEK_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  req_priority;
    logic [15:0] req_id;
    logic [31:0] req_text_handle;
    logic [31:0] req_image_handle;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        note_valid;
    logic [15:0] note_id;
    logic [31:0] note_text_handle;
    logic [31:0] note_image_handle;
    logic        board_empty;
  } out_item_t;

  typedef struct packed {
    logic      busy;
    logic      done;
    out_item_t res;
  } ctrl_stat_t;

endpackage
`default_nettype wire

// ===== design/tspq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tspq_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tspq_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/tspq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tspq_ctrl
// Sequencer: id allocation, ordered insert, search and removal over the RAM.
// ----------------------------------------------------------------------------
module tspq_ctrl #(
  parameter int CAPACITY      = 64,
  parameter int ID_BITS       = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int HANDLE_BITS   = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire tspq_pkg::in_item_t      in_i,
  input  wire logic                    out_free_i,
  output logic                         ram_we_o,
  output logic [$clog2(CAPACITY)-1:0]  ram_waddr_o,
  output logic [ID_BITS+PRIORITY_BITS+2*HANDLE_BITS-1:0] ram_wdata_o,
  output logic [$clog2(CAPACITY)-1:0]  ram_raddr_o,
  input  wire logic [ID_BITS+PRIORITY_BITS+2*HANDLE_BITS-1:0] ram_rdata_i,
  output tspq_pkg::ctrl_stat_t         stat_o
);
  import tspq_pkg::*;

  localparam int AW      = $clog2(CAPACITY);
  localparam int CW      = $clog2(CAPACITY + 1);
  localparam int EW      = ID_BITS + PRIORITY_BITS + 2 * HANDLE_BITS;
  localparam int IdSpace = 1 << ID_BITS;
  localparam int PrioMax = (1 << PRIORITY_BITS) - 1;

  state_e                   state_q, state_d;
  in_item_t                 item_q, item_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            pos_q, pos_d;
  logic [CW-1:0]            count_q, count_d;
  logic [ID_BITS-1:0]       cand_q, cand_d;
  logic [ID_BITS-1:0]       last_q, last_d;
  out_item_t                res_q, res_d;

  logic [ID_BITS-1:0]       rd_id;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [HANDLE_BITS-1:0]   rd_text, rd_image;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic                     accept, full, at_end, hit;
  logic [CW-1:0]            idx_inc, idx_dec;

  assign rd_id    = ram_rdata_i[EW-1 -: ID_BITS];
  assign rd_prio  = ram_rdata_i[2*HANDLE_BITS +: PRIORITY_BITS];
  assign rd_text  = ram_rdata_i[HANDLE_BITS +: HANDLE_BITS];
  assign rd_image = ram_rdata_i[0 +: HANDLE_BITS];

  assign new_prio = (32'(item_q.req_priority) > PrioMax) ? PRIORITY_BITS'(PrioMax)
                                                          : PRIORITY_BITS'(item_q.req_priority);
  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign full    = (32'(count_q) >= CAPACITY) || (32'(count_q) >= IdSpace);
  assign at_end  = (idx_q == count_q);
  assign hit     = (16'(rd_id) == item_q.req_id);
  assign idx_inc = idx_q + 1'b1;
  assign idx_dec = idx_q - 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_i.action)
            ACT_POST:   state_d = full ? S_DONE : S_ALLOC_RD;
            ACT_PEEK:   state_d = (count_q == '0) ? S_DONE : S_PEEK_RD;
            default:    state_d = S_FIND_RD;
          endcase
        end
      end
      S_ALLOC_RD:  state_d = at_end ? S_POS_RD : S_ALLOC_CMP;
      S_ALLOC_CMP: state_d = S_ALLOC_RD;
      S_POS_RD:    state_d = at_end ? S_INS_RD : S_POS_CMP;
      S_POS_CMP:   state_d = (rd_prio <= new_prio) ? S_POS_RD : S_INS_RD;
      S_INS_RD:    state_d = (idx_q == pos_q) ? S_INS_PUT : S_INS_WR;
      S_INS_WR:    state_d = S_INS_RD;
      S_INS_PUT:   state_d = S_DONE;
      S_FIND_RD:   state_d = at_end ? S_DONE : S_FIND_CMP;
      S_FIND_CMP: begin
        if (!hit) begin
          state_d = S_FIND_RD;
        end else if (item_q.action == ACT_CLEAR) begin
          state_d = S_DEL_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DEL_RD:    state_d = (idx_inc == count_q) ? S_DONE : S_DEL_WR;
      S_DEL_WR:    state_d = S_DEL_RD;
      S_PEEK_RD:   state_d = S_PEEK_CMP;
      S_PEEK_CMP:  state_d = S_DONE;
      S_DONE:      state_d = out_free_i ? S_IDLE : S_DONE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_d      = item_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    count_d     = count_q;
    cand_d      = cand_q;
    last_d      = last_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q[AW-1:0];
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = idx_q[AW-1:0];
    stat_o.busy = (state_q != S_IDLE);
    stat_o.done = 1'b0;
    stat_o.res  = res_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = in_i;
          idx_d  = '0;
          cand_d = last_q + 1'b1;
          res_d  = '{status: STAT_MISS, note_valid: 1'b0, note_id: '0,
                     note_text_handle: '0, note_image_handle: '0,
                     board_empty: (count_q == '0)};
          if (in_i.action == ACT_POST && full) begin
            res_d.status = STAT_FULL;
          end
        end
      end
      S_ALLOC_RD: begin
        if (at_end) begin
          last_d = cand_q;
          idx_d  = '0;
        end
      end
      S_ALLOC_CMP: begin
        if (rd_id == cand_q) begin
          cand_d = cand_q + 1'b1;
          idx_d  = '0;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_POS_RD: begin
        if (at_end) begin
          pos_d = idx_q;
          idx_d = count_q;
        end
      end
      S_POS_CMP: begin
        if (rd_prio <= new_prio) begin
          idx_d = idx_inc;
        end else begin
          pos_d = idx_q;
          idx_d = count_q;
        end
      end
      S_INS_RD: begin
        ram_raddr_o = idx_dec[AW-1:0];
      end
      S_INS_WR: begin
        ram_we_o = 1'b1;
        idx_d    = idx_dec;
      end
      S_INS_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q[AW-1:0];
        ram_wdata_o = {cand_q, new_prio, HANDLE_BITS'(item_q.req_text_handle),
                       HANDLE_BITS'(item_q.req_image_handle)};
        count_d     = count_q + 1'b1;
        res_d = '{status: STAT_OK, note_valid: 1'b1, note_id: 16'(cand_q),
                  note_text_handle: 32'(HANDLE_BITS'(item_q.req_text_handle)),
                  note_image_handle: 32'(HANDLE_BITS'(item_q.req_image_handle)),
                  board_empty: 1'b0};
      end
      S_FIND_CMP: begin
        if (hit) begin
          res_d = '{status: STAT_OK, note_valid: 1'b1, note_id: 16'(rd_id),
                    note_text_handle: 32'(rd_text), note_image_handle: 32'(rd_image),
                    board_empty: 1'b0};
        end else begin
          idx_d = idx_inc;
        end
      end
      S_DEL_RD: begin
        ram_raddr_o = idx_inc[AW-1:0];
        if (idx_inc == count_q) begin
          count_d           = count_q - 1'b1;
          res_d.board_empty = (count_q == CW'(1));
        end
      end
      S_DEL_WR: begin
        ram_we_o = 1'b1;
        idx_d    = idx_inc;
      end
      S_PEEK_RD: begin
        ram_raddr_o = '0;
      end
      S_PEEK_CMP: begin
        res_d = '{status: STAT_OK, note_valid: 1'b1, note_id: 16'(rd_id),
                  note_text_handle: 32'(rd_text), note_image_handle: 32'(rd_image),
                  board_empty: 1'b0};
      end
      S_DONE: begin
        stat_o.done = out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    cand_q <= cand_d;
    res_q  <= res_d;
  end

endmodule
`default_nettype wire

// ===== design/tagged_stable_priority_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_stable_priority_queue_top
// Priority-sorted message store with rolling id allocation.
// ----------------------------------------------------------------------------
// One item is worked at a time; entries live in one RAM with a registered read,
// and every scan or shift step is a read state and a compare or write state.
// Post probes candidate ids over the stored entries and repeats the probe while
// the candidate id is in use, so its worst case is quadratic in the number of
// stored entries; it then searches for the slot and shifts. Clear moves each
// later entry up. A result waits in an output register, and a new item is taken
// while it waits.
module tagged_stable_priority_queue_top #(
  parameter int CAPACITY      = tspq_pkg::TspqCapacity,
  parameter int ID_BITS       = tspq_pkg::TspqIdBits,
  parameter int PRIORITY_BITS = tspq_pkg::TspqPriorityBits,
  parameter int HANDLE_BITS   = tspq_pkg::TspqHandleBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire tspq_pkg::in_item_t   in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output tspq_pkg::out_item_t       out_o
);
  import tspq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = ID_BITS + PRIORITY_BITS + 2 * HANDLE_BITS;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  ctrl_stat_t    stat;
  logic          out_free;
  logic          out_valid_q;
  out_item_t     out_q;

  assign out_free = !out_valid_q || !out_stall_i;

  tspq_ram #(
    .Width(EW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  tspq_ctrl #(
    .CAPACITY     (CAPACITY),
    .ID_BITS      (ID_BITS),
    .PRIORITY_BITS(PRIORITY_BITS),
    .HANDLE_BITS  (HANDLE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .out_free_i (out_free),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .stat_o     (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      out_q <= stat.res;
    end
  end

  assign in_stall_o  = stat.busy;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending result");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after taking an item");

  a_note_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.note_valid) |-> (out_o.status == STAT_OK))
    else $error("entry carried with non-ok status");

endmodule
`default_nettype wire
